// ===== sv/mmn_pkg.sv =====
// Shared types and constants for the min-max normalize unit.
// No dependencies.
package mmn_pkg;
	localparam int PIX_W   = 16;
	localparam int NUM_W   = 2 * PIX_W + 1;
	localparam int DIV_W   = PIX_W + 1;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int Q_DEPTH = 2;

	localparam logic FUNC_MEASURE = 1'b0;
	localparam logic FUNC_SCALE   = 1'b1;

	localparam logic REG_TARGET_LOW  = 1'b0;
	localparam logic REG_TARGET_HIGH = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [PIX_W-1:0] min_val;
		logic [PIX_W-1:0] max_val;
		logic             last;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;
endpackage

// ===== sv/mmn_if.sv =====
// Valid/ready channel interfaces for the min-max normalize unit.
// Depends on mmn_pkg.
interface mmn_in_if;
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic [mmn_pkg::PIX_W-1:0] pixel;
	logic                     first;
	logic                     last;
	modport source (output valid, func, pixel, first, last, input ready);
	modport sink (input valid, func, pixel, first, last, output ready);
endinterface

interface mmn_out_if;
	logic                     valid;
	logic                     ready;
	logic [mmn_pkg::PIX_W-1:0] scaled_pixel;
	logic                     passed_through;
	logic                     end_of_image;
	modport source (output valid, scaled_pixel, passed_through, end_of_image, input ready);
	modport sink (input valid, scaled_pixel, passed_through, end_of_image, output ready);
endinterface

// ===== sv/min_max_normalize_unit.sv =====
// Top level of the min-max normalize unit: config registers and wiring.
// Depends on mmn_pkg, mmn_if, mmn_queue, mmn_front, mmn_back.
//
// Usage:
//  pix_in carries pixel requests. func=0 (measure) updates the running
//  min/max and yields no result; first restarts them at the pixel.
//  func=1 (scale) yields one result on pix_out per request, in order.
//  cfg_we/cfg_index/cfg_wdata write target_low (0) and target_high (1);
//  write only while the unit is idle. Bounds are swapped if low > high.
// Flow:
//  Measure requests are taken one per cycle while the queue is not full. A
//  scale request passes through pop, multiply, add, 33 divide steps and
//  clamp; the back end takes no new request until its result is taken, so
//  an output stall holds it. The divider yields one quotient bit per cycle.
//  Pass-through and below-min results go from multiply straight to the
//  output. A 2-entry queue decouples the front so measure requests
//  keep flowing while the back end divides.
// Reset: min=all ones, max=0, target 0..255; queue and output empty.
// Stall: when pix_out.ready is low the result holds, the back end waits,
//  and pix_in.ready drops once the queue is full.
module min_max_normalize_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	mmn_in_if.sink                    pix_in,
	mmn_out_if.source                 pix_out,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [mmn_pkg::PIX_W-1:0] cfg_wdata
);
	logic [mmn_pkg::PIX_W-1:0] tlow_q, thigh_q, lo, hi;
	mmn_pkg::q_entry_t  push_data, pop_data;
	mmn_pkg::q_status_t q_status;
	logic push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlow_q  <= '0;
			thigh_q <= mmn_pkg::PIX_W'(255);
		end else if (cfg_we) begin
			case (cfg_index)
				mmn_pkg::REG_TARGET_LOW:  tlow_q  <= cfg_wdata;
				mmn_pkg::REG_TARGET_HIGH: thigh_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ordered bounds
	assign lo = (tlow_q > thigh_q) ? thigh_q : tlow_q;
	assign hi = (tlow_q > thigh_q) ? tlow_q : thigh_q;

	mmn_front u_front (
		.clk(clk), .arst_n(arst_n), .pix_in(pix_in), .q_status(q_status),
		.push(push), .push_data(push_data)
	);

	mmn_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .pop_data(pop_data), .status(q_status)
	);

	mmn_back u_back (
		.clk(clk), .arst_n(arst_n), .lo(lo), .hi(hi), .q_status(q_status),
		.pop_data(pop_data), .pop(pop), .pix_out(pix_out)
	);

	// a scaled (not passed) result lies inside the target range
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.passed_through) |->
		(pix_out.scaled_pixel >= lo && pix_out.scaled_pixel <= hi))
		else $error("scaled pixel outside target range");

	// queue never pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full))
		else $error("queue overflow");

	// queue never popped while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_status.empty))
		else $error("queue underflow");

	// a taken result is not shown again in the next cycle
	a_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.ready) |=> !pix_out.valid)
		else $error("result repeated");
endmodule

// ===== sv/mmn_queue.sv =====
// Two-entry request queue between front and back.
// Depends on mmn_pkg.
module mmn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mmn_pkg::q_entry_t push_data,
	input  logic              pop,
	output mmn_pkg::q_entry_t pop_data,
	output mmn_pkg::q_status_t status
);
	mmn_pkg::q_entry_t mem_q [mmn_pkg::Q_DEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign status.full  = (count_q == 2'(mmn_pkg::Q_DEPTH));
	assign status.empty = (count_q == 2'd0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end
endmodule

// ===== sv/mmn_front.sv =====
// Front end: takes requests, tracks running min/max, queues scale requests.
// Depends on mmn_pkg, mmn_if.
module mmn_front (
	input  logic              clk,
	input  logic              arst_n,
	mmn_in_if.sink            pix_in,
	input  mmn_pkg::q_status_t q_status,
	output logic              push,
	output mmn_pkg::q_entry_t push_data
);
	logic [mmn_pkg::PIX_W-1:0] min_q, max_q;
	logic take;

	assign pix_in.ready = !q_status.full;
	assign take = pix_in.valid && pix_in.ready;
	assign push = take && (pix_in.func == mmn_pkg::FUNC_SCALE);
	// min/max snapshot travels with the request
	assign push_data.pixel   = pix_in.pixel;
	assign push_data.min_val = min_q;
	assign push_data.max_val = max_q;
	assign push_data.last    = pix_in.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			max_q <= '0;
		end else if (take && pix_in.func == mmn_pkg::FUNC_MEASURE) begin
			if (pix_in.first) begin
				min_q <= pix_in.pixel;
				max_q <= pix_in.pixel;
			end else begin
				if (pix_in.pixel < min_q) min_q <= pix_in.pixel;
				if (pix_in.pixel > max_q) max_q <= pix_in.pixel;
			end
		end
	end
endmodule

// ===== sv/mmn_back.sv =====
// Back end: multiply, bit-serial divide, clamp, output register; pass-through and below-min skip the divide.
// Depends on mmn_pkg, mmn_if.
module mmn_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mmn_pkg::PIX_W-1:0] lo,
	input  logic [mmn_pkg::PIX_W-1:0] hi,
	input  mmn_pkg::q_status_t        q_status,
	input  mmn_pkg::q_entry_t         pop_data,
	output logic                      pop,
	mmn_out_if.source                 pix_out
);
	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_DIV, S_FIN, S_HOLD} state_t;
	state_t state_q;

	mmn_pkg::q_entry_t ent_q;
	logic [2*mmn_pkg::PIX_W-1:0] prod_q;
	logic [mmn_pkg::NUM_W-1:0]   num_q;
	logic [mmn_pkg::DIV_W-1:0]   rem_q;
	logic [mmn_pkg::CNT_W-1:0]   cnt_q;
	logic [mmn_pkg::PIX_W-1:0]   res_q;
	logic pass_q, last_q;

	logic [mmn_pkg::PIX_W-1:0] span, rng, diff;
	logic [mmn_pkg::DIV_W-1:0] dvs;
	logic [mmn_pkg::DIV_W:0]   rem_sh;
	logic ge;

	assign span   = ent_q.max_val - ent_q.min_val;
	assign rng    = hi - lo;
	assign diff   = ent_q.pixel - ent_q.min_val;
	assign dvs    = {span, 1'b0};
	assign rem_sh = {rem_q, num_q[mmn_pkg::NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs};

	assign pop                    = (state_q == S_IDLE) && !q_status.empty;
	assign pix_out.valid          = (state_q == S_HOLD);
	assign pix_out.scaled_pixel   = res_q;
	assign pix_out.passed_through = pass_q;
	assign pix_out.end_of_image   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ent_q   <= '0;
			prod_q  <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			res_q   <= '0;
			pass_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						ent_q   <= pop_data;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					last_q <= ent_q.last;
					prod_q <= (2*mmn_pkg::PIX_W)'(diff) * (2*mmn_pkg::PIX_W)'(rng);
					if (ent_q.min_val >= ent_q.max_val ||
						(ent_q.min_val == lo && ent_q.max_val == hi)) begin
						res_q   <= ent_q.pixel;
						pass_q  <= 1'b1;
						state_q <= S_HOLD;
					end else if (ent_q.pixel < ent_q.min_val) begin
						res_q   <= lo;
						pass_q  <= 1'b0;
						state_q <= S_HOLD;
					end else begin
						pass_q  <= 1'b0;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					num_q   <= {prod_q, 1'b0} + mmn_pkg::NUM_W'(span);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring division, one quotient bit per cycle
					num_q <= {num_q[mmn_pkg::NUM_W-2:0], ge};
					rem_q <= ge ? mmn_pkg::DIV_W'(rem_sh - {1'b0, dvs})
						: rem_sh[mmn_pkg::DIV_W-1:0];
					cnt_q <= cnt_q + mmn_pkg::CNT_W'(1);
					if (cnt_q == mmn_pkg::CNT_W'(mmn_pkg::NUM_W - 1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (num_q > mmn_pkg::NUM_W'(rng)) res_q <= hi;
					else res_q <= lo + num_q[mmn_pkg::PIX_W-1:0];
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (pix_out.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
